@@ rtl/dbe_pkg.sv @@
// Package: shared types, constants and tables for the bearing estimator.
package dbe_pkg;

  localparam int NumCalEntries = 6;
  localparam int AngleBits     = 16;
  localparam int SampleBits    = 16;
  localparam int FiltBits      = SampleBits + 8;
  localparam int CordicSteps   = 16;
  localparam int CordicW       = 32;
  localparam int GainInv       = 39797;
  localparam int StepW         = $clog2(CordicSteps + 1);
  localparam int CalIdxW       = $clog2(NumCalEntries + 1);

  typedef enum logic [2:0] {
    REQ_SAMPLE    = 3'd0,
    REQ_CALIBRATE = 3'd1,
    REQ_NUDGE_ENT = 3'd2,
    REQ_NUDGE_GLB = 3'd3,
    REQ_SET_OFF   = 3'd4,
    REQ_WRITE_ENT = 3'd5,
    REQ_READ_ENT  = 3'd6,
    REQ_NONE      = 3'd7
  } req_e;

  typedef enum logic [1:0] {
    CFG_RATE    = 2'd0,
    CFG_BETA    = 2'd1,
    CFG_QUANTUM = 2'd2
  } cfg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CTRL,
    ST_FILT_MUL,
    ST_FILT_ADD,
    ST_VEC_INIT,
    ST_VEC_ITER,
    ST_ROT_INIT,
    ST_ROT_ITER,
    ST_SCALE_MUL1,
    ST_SCALE_MUL2,
    ST_SCALE_OUT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic filt_mul;
    logic filt_add;
    logic vec_init;
    logic vec_step;
    logic rot_init;
    logic rot_step;
    logic scale_mul1;
    logic scale_mul2;
    logic scale_out;
    logic ctrl_req;
  } dp_cmd_t;

  typedef struct packed {
    logic             is_sample;
    logic             report_due;
    logic [StepW-1:0] step;
  } dp_sts_t;

  function automatic logic [CordicW-1:0] atan_lut(input logic [4:0] i);
    logic [CordicW-1:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/dbe_ctrl.sv @@
// Controller: sequences one request through the datapath.
module dbe_ctrl
  import dbe_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  logic    out_stall_i,
  output logic    out_valid_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o,
  output logic    res_load_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // The output register is loaded only in ST_OUT and held until transferred.
  logic out_valid_q, out_valid_d;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    res_load_o  = 1'b0;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (sts_i.is_sample) begin
            state_d = ST_FILT_MUL;
          end else begin
            state_d = ST_CTRL;
          end
        end
      end
      ST_CTRL: begin
        cmd_o.ctrl_req = 1'b1;
        state_d = ST_OUT;
      end
      ST_FILT_MUL: begin
        cmd_o.filt_mul = 1'b1;
        state_d = ST_FILT_ADD;
      end
      ST_FILT_ADD: begin
        cmd_o.filt_add = 1'b1;
        state_d = ST_VEC_INIT;
      end
      ST_VEC_INIT: begin
        if (sts_i.report_due) begin
          cmd_o.vec_init = 1'b1;
          state_d = ST_VEC_ITER;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_VEC_ITER: begin
        cmd_o.vec_step = 1'b1;
        if (sts_i.step == StepW'(CordicSteps - 1)) state_d = ST_ROT_INIT;
      end
      ST_ROT_INIT: begin
        cmd_o.rot_init = 1'b1;
        state_d = ST_ROT_ITER;
      end
      ST_ROT_ITER: begin
        cmd_o.rot_step = 1'b1;
        if (sts_i.step == StepW'(CordicSteps - 1)) state_d = ST_SCALE_MUL1;
      end
      ST_SCALE_MUL1: begin
        cmd_o.scale_mul1 = 1'b1;
        state_d = ST_SCALE_MUL2;
      end
      ST_SCALE_MUL2: begin
        cmd_o.scale_mul2 = 1'b1;
        state_d = ST_SCALE_OUT;
      end
      ST_SCALE_OUT: begin
        cmd_o.scale_out = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // Datapath flags whether a result exists; wait for a free output slot.
        if (!(out_valid_q && out_stall_i)) begin
          res_load_o  = 1'b1;
          out_valid_d = sts_i.report_due;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/dbe_dpath.sv @@
// Datapath: filter, shared CORDIC, offset store and result register.
module dbe_dpath
  import dbe_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [15:0]                  cfg_data_i,
  input  logic                         in_xfer_i,
  input  logic [2:0]                   req_type_i,
  input  logic signed [SampleBits-1:0] sample_i_i,
  input  logic signed [SampleBits-1:0] sample_q_i,
  input  logic signed [AngleBits-1:0]  angle_arg_i,
  input  logic [2:0]                   entry_index_i,
  input  dp_cmd_t                      cmd_i,
  input  logic                         res_load_i,
  output dp_sts_t                      sts_o,
  output logic                         result_kind_o,
  output logic signed [SampleBits-1:0] in_phase_out_o,
  output logic signed [SampleBits-1:0] quadrature_out_o,
  output logic signed [AngleBits-1:0]  raw_bearing_o,
  output logic signed [AngleBits-1:0]  readback_value_o
);

  localparam int CW = FiltBits + 3; // CORDIC growth headroom

  logic [2:0]  rate_q;
  logic [15:0] beta_q;
  logic [8:0]  quantum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q    <= 3'd2;
      beta_q    <= 16'd197;
      quantum_q <= 9'd100;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RATE:    rate_q    <= cfg_data_i[2:0];
        CFG_BETA:    beta_q    <= cfg_data_i;
        CFG_QUANTUM: quantum_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // Held request fields
  logic [2:0]                   req_q;
  logic signed [SampleBits-1:0] si_q, sq_q;
  logic [AngleBits-1:0]         arg_q;
  logic [2:0]                   idx_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer_i) begin
      req_q <= req_type_i;
      si_q  <= sample_i_i;
      sq_q  <= sample_q_i;
      arg_q <= angle_arg_i;
      idx_q <= entry_index_i;
    end
  end

  logic signed [FiltBits-1:0] fi_q, fq_q;
  logic [AngleBits-1:0]       inst_q, glob_q;
  logic [AngleBits-1:0]       cal_q [NumCalEntries];
  logic [8:0]                 cnt_q;
  logic                       due_q;

  logic rate_ok;
  logic [AngleBits-1:0] sel_ent;
  assign rate_ok = rate_q < 3'(NumCalEntries);
  always_comb begin
    sel_ent = '0;
    for (int k = 0; k < NumCalEntries; k++) begin
      if (rate_q == 3'(k)) sel_ent = cal_q[k];
    end
  end

  // Filter: products registered, then round and accumulate.
  logic signed [FiltBits+1:0]  di, dq;
  logic signed [FiltBits+18:0] pi_q, pq_q;
  assign di = (FiltBits + 2)'(si_q) * (FiltBits + 2)'(256) - (FiltBits + 2)'(fi_q);
  assign dq = (FiltBits + 2)'(sq_q) * (FiltBits + 2)'(256) - (FiltBits + 2)'(fq_q);

  function automatic logic signed [FiltBits-1:0] filt_upd(
    input logic signed [FiltBits-1:0]  f,
    input logic signed [FiltBits+18:0] p
  );
    logic signed [FiltBits+18:0] r, s;
    logic signed [FiltBits+18:0] hi, lo;
    r  = (p + (FiltBits + 19)'(32768)) >>> 16;
    s  = (FiltBits + 19)'(f) + r;
    hi = (FiltBits + 19)'((1 <<< (FiltBits - 1)) - 1);
    lo = -hi - 1;
    if (s > hi) s = hi;
    else if (s < lo) s = lo;
    return s[FiltBits-1:0];
  endfunction

  // CORDIC registers, shared by vectoring and rotation
  logic signed [CW-1:0]      cx_q, cy_q;
  logic [CordicW-1:0]        cz_q;
  logic [StepW-1:0]          step_q;
  logic                      zero_q;

  logic signed [CW-1:0] sx, sy;
  assign sx = cx_q >>> step_q;
  assign sy = cy_q >>> step_q;

  logic [CordicW-1:0] at;
  assign at = atan_lut(5'(step_q));

  logic [CordicW-1:0] rot_a;
  assign rot_a = {AngleBits'(sel_ent + glob_q), {(CordicW - AngleBits){1'b0}}};

  // Scaling
  logic signed [CW+9:0]  m1x_q, m1y_q;
  logic signed [CW+26:0] m2x_q, m2y_q;
  logic [9:0]            count;
  assign count = {1'b0, cnt_q} + 10'd1;

  function automatic logic signed [SampleBits-1:0] scale_sat(
    input logic signed [CW+26:0] p
  );
    logic signed [CW+26:0] r, hi, lo;
    r  = (p + (CW + 27)'(64'sd1 <<< 32)) >>> 33;
    hi = (CW + 27)'((1 <<< (SampleBits - 1)) - 1);
    lo = -hi - 1;
    if (r > hi) r = hi;
    else if (r < lo) r = lo;
    return r[SampleBits-1:0];
  endfunction

  logic signed [SampleBits-1:0] oi_q, oq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fi_q   <= '0;
      fq_q   <= '0;
      inst_q <= '0;
      glob_q <= '0;
      cnt_q  <= '0;
      due_q  <= 1'b0;
      step_q <= '0;
      for (int k = 0; k < NumCalEntries; k++) cal_q[k] <= '0;
    end else begin
      if (cmd_i.filt_add) begin
        fi_q <= filt_upd(fi_q, pi_q);
        fq_q <= filt_upd(fq_q, pq_q);
        if (count >= ((quantum_q == 9'd0) ? 10'd1 : {1'b0, quantum_q})) begin
          due_q <= 1'b1;
        end else begin
          due_q <= 1'b0;
          cnt_q <= count[8:0];
        end
      end
      if (cmd_i.vec_init || cmd_i.rot_init) step_q <= '0;
      else if (cmd_i.vec_step || cmd_i.rot_step) step_q <= step_q + 1'b1;
      // Vectoring has finished all steps by the rotation start.
      if (cmd_i.rot_init) begin
        inst_q <= zero_q ? '0 :
          AngleBits'((cz_q + (CordicW'(1) << (CordicW - 1 - AngleBits)))
                     >> (CordicW - AngleBits));
      end
      if (cmd_i.scale_out) cnt_q <= '0;
      if (cmd_i.ctrl_req) begin
        due_q <= (req_q == REQ_READ_ENT);
        unique case (req_q)
          REQ_CALIBRATE: if (rate_ok) cal_q[rate_q] <= arg_q - inst_q;
          REQ_NUDGE_ENT: if (rate_ok) cal_q[rate_q] <= sel_ent + arg_q;
          REQ_NUDGE_GLB: glob_q <= glob_q + arg_q;
          REQ_SET_OFF:   glob_q <= arg_q - inst_q - sel_ent;
          REQ_WRITE_ENT: begin
            if (idx_q < 3'(NumCalEntries)) cal_q[idx_q] <= arg_q;
            else if (idx_q == 3'(NumCalEntries)) glob_q <= arg_q;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.filt_mul) begin
      pi_q <= (FiltBits + 19)'(di) * $signed({1'b0, beta_q});
      pq_q <= (FiltBits + 19)'(dq) * $signed({1'b0, beta_q});
    end
    if (cmd_i.vec_init) begin
      zero_q <= (fi_q == '0) && (fq_q == '0);
      if (fi_q < 0) begin
        cx_q <= -CW'(fi_q);
        cy_q <= -CW'(fq_q);
        cz_q <= 32'h80000000;
      end else begin
        cx_q <= CW'(fi_q);
        cy_q <= CW'(fq_q);
        cz_q <= '0;
      end
    end else if (cmd_i.vec_step) begin
      if (!cy_q[CW-1]) begin
        cx_q <= cx_q + sy; cy_q <= cy_q - sx; cz_q <= cz_q + at;
      end else begin
        cx_q <= cx_q - sy; cy_q <= cy_q + sx; cz_q <= cz_q - at;
      end
    end else if (cmd_i.rot_init) begin
      if (rot_a[31] != rot_a[30]) begin
        cx_q <= -CW'(fi_q);
        cy_q <= -CW'(fq_q);
        cz_q <= rot_a - 32'h80000000;
      end else begin
        cx_q <= CW'(fi_q);
        cy_q <= CW'(fq_q);
        cz_q <= rot_a;
      end
    end else if (cmd_i.rot_step) begin
      if (!cz_q[CordicW-1]) begin
        cx_q <= cx_q - sy; cy_q <= cy_q + sx; cz_q <= cz_q - at;
      end else begin
        cx_q <= cx_q + sy; cy_q <= cy_q - sx; cz_q <= cz_q + at;
      end
    end
    if (cmd_i.scale_mul1) begin
      m1x_q <= (CW + 10)'(cx_q) * $signed({1'b0, count});
      m1y_q <= (CW + 10)'(cy_q) * $signed({1'b0, count});
    end
    if (cmd_i.scale_mul2) begin
      m2x_q <= (CW + 27)'(m1x_q) * $signed({1'b0, 16'(GainInv)});
      m2y_q <= (CW + 27)'(m1y_q) * $signed({1'b0, 16'(GainInv)});
    end
    if (cmd_i.scale_out) begin
      oi_q <= scale_sat(m2x_q);
      oq_q <= scale_sat(m2y_q);
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (res_load_i) begin
      if (req_q == REQ_SAMPLE) begin
        result_kind_o    <= 1'b0;
        in_phase_out_o   <= oi_q;
        quadrature_out_o <= oq_q;
        raw_bearing_o    <= inst_q;
        readback_value_o <= '0;
      end else begin
        result_kind_o    <= 1'b1;
        in_phase_out_o   <= '0;
        quadrature_out_o <= '0;
        raw_bearing_o    <= '0;
        readback_value_o <= (idx_q < 3'(NumCalEntries)) ? cal_q[idx_q] :
                            (idx_q == 3'(NumCalEntries)) ? glob_q : '0;
      end
    end
  end

  assign sts_o.is_sample  = (req_type_i == REQ_SAMPLE);
  assign sts_o.report_due = due_q;
  assign sts_o.step       = step_q;

endmodule

@@ rtl/doppler_bearing_estimator.sv @@
// Top level: pseudo-Doppler bearing estimator, controller plus datapath.
// A sample transfer that does not close a quantum steps through registering
// the request, multiply, accumulate and the quantum check. A sample closing
// a quantum then goes on with two 16-step passes of the one shared CORDIC
// (vectoring for atan2, then rotation by calibration plus global offset),
// two registered multiplies for the count and gain scaling, a rounding step
// and the result state. Other requests pass through a control step and the
// result state. A result still stalled at the output holds the block in its
// result state until it is transferred. One request is in work at a time;
// the result register holds a result while the next request is accepted.
// Configuration index 0 selects rate, 1 sets beta, 2 sets the samples per
// report; write configuration only while the block is idle.
module doppler_bearing_estimator
  import dbe_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [15:0]                  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [2:0]                   req_type_i,
  input  logic signed [SampleBits-1:0] sample_i_i,
  input  logic signed [SampleBits-1:0] sample_q_i,
  input  logic signed [AngleBits-1:0]  angle_arg_i,
  input  logic [2:0]                   entry_index_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         result_kind_o,
  output logic signed [SampleBits-1:0] in_phase_out_o,
  output logic signed [SampleBits-1:0] quadrature_out_o,
  output logic signed [AngleBits-1:0]  raw_bearing_o,
  output logic signed [AngleBits-1:0]  readback_value_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    res_load;

  dbe_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_stall_i, .out_valid_o,
    .sts_i(sts), .cmd_o(cmd), .res_load_o(res_load)
  );

  dbe_dpath u_dpath (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_xfer_i(in_valid_i && !in_stall_o),
    .req_type_i, .sample_i_i, .sample_q_i, .angle_arg_i, .entry_index_i,
    .cmd_i(cmd), .res_load_i(res_load), .sts_o(sts),
    .result_kind_o, .in_phase_out_o, .quadrature_out_o, .raw_bearing_o,
    .readback_value_o
  );

endmodule

@@ rtl/dbe_checker.sv @@
// Checker: port-level properties of the bearing estimator.
module dbe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        result_kind_o,
  input logic [15:0] readback_value_o,
  input logic [15:0] raw_bearing_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(raw_bearing_o))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("accepted two requests back to back");

  a_report_zero_rb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !result_kind_o |-> readback_value_o == 16'd0)
    else $error("bearing report carries readback value");

endmodule

bind doppler_bearing_estimator dbe_checker u_dbe_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .result_kind_o, .readback_value_o, .raw_bearing_o
);
